// ===== sv/date_add_days_macros.svh =====
// Assertion macros shared by the date offset block.
// No dependencies; included by the controller and the datapath.
`ifndef DATE_ADD_DAYS_MACROS_SVH
`define DATE_ADD_DAYS_MACROS_SVH

`ifndef ASSERT_OFF
`define DAD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dad assertion failed");
`define DAD_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dad reset assertion failed");
`else
`define DAD_ASSERT(lbl, clk, rst_n, prop)
`define DAD_ASSERT_RST(lbl, clk, prop)
`endif

`endif

// ===== sv/dad_pkg.sv =====
// Types, codes and the month length table of the date offset block.
// No dependencies; used by dad_ctrl, dad_dp and date_add_days.
package dad_pkg;

    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_APR = 4'd3;
    localparam logic [3:0] MONTH_JUN = 4'd5;
    localparam logic [3:0] MONTH_SEP = 4'd8;
    localparam logic [3:0] MONTH_NOV = 4'd10;
    localparam logic [4:0] MONTHS_PER_YEAR = 5'd12;
    localparam logic [15:0] DIV25_INV = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    typedef struct packed {
        logic [15:0]        start_year;
        logic [3:0]         start_month;
        logic [4:0]         start_day;
        logic signed [15:0] days_to_add;
    } t_dad_in;

    typedef struct packed {
        logic [15:0] result_year;
        logic [3:0]  result_month;
        logic [4:0]  result_day;
        logic        year_overflow;
    } t_dad_out;

    typedef struct packed {
        logic load;
        logic walk;
        logic capture;
    } t_dad_cmd;

    typedef struct packed {
        logic walk_done;
    } t_dad_sts;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/date_add_days.sv =====
// Top level of the Gregorian date offset block: controller plus datapath.
// Depends on dad_pkg, dad_ctrl and dad_dp.
//
//  channel  valid        stall        payload
//  in       i_in_valid   o_in_stall   i_in_data  (t_dad_in)
//  out      o_out_valid  i_out_stall  o_out_data (t_dad_out)
//
// After an input transfer, the date registers are loaded and then walk one month per cycle
// (up to about 1080 months for the largest offset) until the day fits; a capture then follows.
// The next input transfer can follow in the cycle after capture; no new date is taken mid-walk.
// Reset clears the controller and the output valid; no memory to clear.
// A stalled output holds in its register; the next input transfer is taken meanwhile,
// and that item holds in the walk state until the output register frees.
module date_add_days
    import dad_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dad_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_dad_out o_out_data
);

    t_dad_cmd cmd;
    t_dad_sts sts;

    dad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dad_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

// ===== sv/dad_dp.sv =====
// Datapath of the date offset block: date registers, leap test, result register.
// Depends on dad_pkg and date_add_days_macros.svh.
`include "date_add_days_macros.svh"

module dad_dp
    import dad_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dad_in  i_in_data,
    input  t_dad_cmd i_cmd,
    output t_dad_sts o_sts,
    output t_dad_out o_out_data
);

    logic [15:0] r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [15:0] r_day, n_day;
    logic        r_flag, n_flag;
    logic        r_neg, n_neg;
    t_dad_out    r_out, n_out;

    logic        leap;
    logic [15:0] div25_prod;
    logic [4:0]  len;
    logic [4:0]  month_inc;

    always_comb begin
        // multiply by the inverse of 25 modulo 2^16; small products mark multiples of 25
        div25_prod = r_year * DIV25_INV;
        leap = (r_year[1:0] == 2'd0) &&
               (!(div25_prod <= DIV25_MAX) || (r_year[3:0] == 4'd0));
        len = month_len(r_month, leap);
        month_inc = {1'b0, r_month} + 5'd1;
        o_sts.walk_done = r_neg || (r_day < {11'd0, len});
    end

    always_comb begin
        n_year = r_year;
        n_month = r_month;
        n_day = r_day;
        n_flag = r_flag;
        n_neg = r_neg;
        n_out = r_out;
        if (i_cmd.load) begin
            n_year = i_in_data.start_year;
            n_month = i_in_data.start_month;
            n_neg = i_in_data.days_to_add[15];
            n_day = {11'd0, i_in_data.start_day} +
                    (i_in_data.days_to_add[15] ? 16'd0 : 16'(i_in_data.days_to_add));
            n_flag = 1'b0;
        end
        if (i_cmd.walk) begin
            n_day = r_day - {11'd0, len};
            if (month_inc >= MONTHS_PER_YEAR) begin
                n_month = 4'(month_inc - MONTHS_PER_YEAR);
                if (r_year == 16'hFFFF) begin
                    n_year = 16'd0;
                    n_flag = 1'b1;
                end else begin
                    n_year = r_year + 16'd1;
                end
            end else begin
                n_month = month_inc[3:0];
            end
        end
        if (i_cmd.capture) begin
            n_out.result_year = r_year;
            n_out.result_month = r_month;
            n_out.result_day = r_day[4:0];
            n_out.year_overflow = r_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else begin
            r_flag <= n_flag;
        end
        r_year <= n_year;
        r_month <= n_month;
        r_day <= n_day;
        r_neg <= n_neg;
        r_out <= n_out;
    end

    assign o_out_data = r_out;

    `DAD_ASSERT(a_wrap_to_zero, i_clk, i_rst_n, $rose(r_flag) |-> (r_year == 16'd0))
    `DAD_ASSERT(a_walk_not_neg, i_clk, i_rst_n, i_cmd.walk |-> !r_neg)
    `DAD_ASSERT(a_capture_fits, i_clk, i_rst_n, i_cmd.capture |-> o_sts.walk_done)

endmodule

// ===== sv/dad_ctrl.sv =====
// Controller of the date offset block: sequences load, month walk, output.
// Depends on dad_pkg and date_add_days_macros.svh.
`include "date_add_days_macros.svh"

module dad_ctrl
    import dad_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dad_sts i_sts,
    output t_dad_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!i_sts.walk_done) begin
                    o_cmd.walk = 1'b1;
                end else if (!r_out_valid || !i_out_stall) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `DAD_ASSERT_RST(a_rst_clears, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall))
    `DAD_ASSERT(a_accept_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall)
    `DAD_ASSERT(a_out_from_walk, i_clk, i_rst_n,
        $rose(o_out_valid) |-> ($past(r_state == S_WALK) && $past(i_sts.walk_done)))
    `DAD_ASSERT(a_capture_free, i_clk, i_rst_n,
        o_cmd.capture |-> (!r_out_valid || !i_out_stall))

endmodule

// ===== verif/date_add_days_chk.sv =====
// Checker for the date offset block: watches both channels, predicts each result
// date from the transferred start date and offset, and counts mismatches.
// Depends on dad_pkg for the channel payload types and month codes.
module date_add_days_chk
    import dad_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_dad_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_dad_out i_out_data,
    output int       o_fail_count,
    output int       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_dad_out dates_due[$];
    int       fails = 0;
    int       due_count = 0;

    assign o_fail_count = fails;
    assign o_pending    = due_count;

    function automatic bit leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned yr,
                                                  input int unsigned mon);
        if (mon == 32'(MONTH_FEB)) begin
            return leap_year(yr) ? 29 : 28;
        end
        if (mon == 32'(MONTH_APR) || mon == 32'(MONTH_JUN) ||
            mon == 32'(MONTH_SEP) || mon == 32'(MONTH_NOV)) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic t_dad_out date_after(input t_dad_in item);
        int unsigned yr;
        int unsigned mon;
        int unsigned dy;
        int unsigned len;
        t_dad_out    res;
        yr  = 32'(item.start_year);
        mon = 32'(item.start_month);
        dy  = 32'(item.start_day);
        res.year_overflow = 1'b0;
        if (!item.days_to_add[15]) begin
            dy  = dy + 32'(item.days_to_add[15:0]);
            len = days_in_month(yr, mon);
            while (dy >= len) begin
                dy  = dy - len;
                mon = mon + 1;
                if (mon >= 32'(MONTHS_PER_YEAR)) begin
                    mon = mon - 32'(MONTHS_PER_YEAR);
                    yr  = yr + 1;
                    if (yr > 32'hFFFF) begin
                        yr = 0;
                        res.year_overflow = 1'b1;
                    end
                end
                len = days_in_month(yr, mon);
            end
        end
        res.result_year  = yr[15:0];
        res.result_month = mon[3:0];
        res.result_day   = dy[4:0];
        return res;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_dad_out want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (dates_due.size() == 0) begin
                    $display("%0t: unexpected result expected none got %p", $time, i_out_data);
                    fails++;
                end else begin
                    want = dates_due.pop_front();
                    check_field("result_year", want.result_year, i_out_data.result_year);
                    check_field("result_month", 16'(want.result_month),
                                16'(i_out_data.result_month));
                    check_field("result_day", 16'(want.result_day),
                                16'(i_out_data.result_day));
                    check_field("year_overflow", 16'(want.year_overflow),
                                16'(i_out_data.year_overflow));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                dates_due.push_back(date_after(i_in_data));
            end
            due_count = dates_due.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the date offset block: clock, reset, start date stimulus,
// receiver stalls and the final verdict. Depends on dad_pkg, date_add_days
// and date_add_days_chk.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dad_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int LONG_HOLD    = 2500;
    localparam int DRAIN_CYCLES = 1200;
    localparam int PHASE_ITEMS  = 175;

    localparam t_dad_in EDGE_DATES [22] = '{
        '{16'd2024,  4'd1,  5'd28, 16'sd0},
        '{16'd2023,  4'd1,  5'd28, 16'sd0},
        '{16'd1900,  4'd1,  5'd27, 16'sd1},
        '{16'd2000,  4'd1,  5'd27, 16'sd1},
        '{16'd2400,  4'd1,  5'd28, 16'sd0},
        '{16'd0,     4'd0,  5'd0,  16'sd0},
        '{16'd1999,  4'd11, 5'd30, 16'sd1},
        '{16'd2100,  4'd1,  5'd0,  16'sd28},
        '{16'd65535, 4'd11, 5'd30, 16'sd1},
        '{16'd65535, 4'd11, 5'd0,  16'sd31},
        '{16'd65535, 4'd0,  5'd0,  16'sd32767},
        '{16'd0,     4'd0,  5'd0,  16'sd32767},
        '{16'd1234,  4'd5,  5'd6,  -16'sd1},
        '{16'd65535, 4'd15, 5'd31, 16'sh8000},
        '{16'd2020,  4'd12, 5'd5,  16'sd0},
        '{16'd2020,  4'd15, 5'd30, 16'sd0},
        '{16'd2020,  4'd15, 5'd31, 16'sd0},
        '{16'd2021,  4'd3,  5'd31, 16'sd0},
        '{16'd2021,  4'd13, 5'd31, 16'sd40},
        '{16'd65535, 4'd14, 5'd20, 16'sd20},
        '{16'hAAAA,  4'd10, 5'd21, 16'sh5555},
        '{16'h5555,  4'd5,  5'd10, 16'sh2AAA}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_dad_in     in_data = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    t_dad_out    out_data;

    int          in_idle_pct = 0;
    int          out_idle_pct = 0;
    int          hold_requests = 0;
    int          fail_count;
    int          pending;
    int unsigned cycles = 0;

    always #6 i_clk = ~i_clk;

    date_add_days dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    date_add_days_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("date_add_days: mismatch");
            $finish;
        end
    end

    initial begin : result_stalls
        int served;
        served = 0;
        forever begin
            @(posedge i_clk);
            if (served < hold_requests) begin
                served++;
                repeat (LONG_HOLD) begin
                    out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            out_stall <= ($urandom_range(0, 99) < out_idle_pct);
        end
    end

    task automatic send_date(input t_dad_in item);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_dates();
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_dad_in random_date();
        t_dad_in     item;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            item.start_year = 16'($urandom_range(65530, 65535));
        end else if (pick < 25) begin
            item.start_year = 16'($urandom());
        end else if (pick < 35) begin
            item.start_year = 16'(100 * $urandom_range(0, 655));
        end else begin
            item.start_year = 16'($urandom_range(1580, 2420));
        end
        item.start_month = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, 11))
                                                         : 4'($urandom_range(12, 15));
        item.start_day = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 27))
                                                       : 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            item.days_to_add = 16'(16'h8000 | $urandom_range(0, 16'h7FFF));
        end else if (pick < 15) begin
            item.days_to_add = 16'($urandom_range(0, 32767));
        end else if (pick < 35) begin
            item.days_to_add = 16'($urandom_range(0, 3000));
        end else if (pick < 40) begin
            item.days_to_add = '0;
        end else begin
            item.days_to_add = 16'($urandom_range(0, 400));
        end
        return item;
    endfunction

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (EDGE_DATES[k]) begin
            send_date(EDGE_DATES[k]);
        end
        in_idle_pct  = 6;
        out_idle_pct = 80;
        repeat (PHASE_ITEMS) send_date(random_date());
        in_valid <= 1'b0;
        drain_dates();
        in_idle_pct  = 80;
        out_idle_pct = 6;
        repeat (PHASE_ITEMS) send_date(random_date());
        in_idle_pct  = 0;
        out_idle_pct = 0;
        hold_requests++;
        repeat (PHASE_ITEMS) send_date(random_date());
        in_valid <= 1'b0;
        drain_dates();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("date_add_days: match");
        end else begin
            $display("date_add_days: mismatch");
        end
        $finish;
    end

endmodule

// ===== date_add_days.f =====
+incdir+sv
sv/dad_pkg.sv
sv/dad_dp.sv
sv/dad_ctrl.sv
sv/date_add_days.sv
verif/date_add_days_chk.sv
verif/tb_top.sv
